@@ src/base62_number_codec_macros.svh @@
// ----------------------------------------------------------------------------
// Base-62 number codec assertion macros
// Shared property templates for the codec checkers, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BASE62_NUMBER_CODEC_MACROS_SVH
`define BASE62_NUMBER_CODEC_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define B62_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define B62_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/b62_pkg.sv @@
// ----------------------------------------------------------------------------
// Base-62 codec package
// Widths, character codes, shared types and the alphabet mapping functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package b62_pkg;

    localparam int DEFAULT_MAX_DIGITS  = 11;
    localparam int DEFAULT_QUEUE_DEPTH = 2;

    localparam int NUM_W      = 64;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 6;
    localparam int RADIX      = 62;
    localparam int CHUNK_W    = 16;
    localparam int NUM_CHUNKS = NUM_W / CHUNK_W;

    // The radix is 2^6 - 2^1, so acc * 62 is two shifts and a subtract.
    localparam int RADIX_HI_SH = 6;
    localparam int RADIX_LO_SH = 1;

    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;

    localparam logic [DIGIT_W-1:0] LOWER_BASE = 6'd10;
    localparam logic [DIGIT_W-1:0] UPPER_BASE = 6'd36;

    typedef struct packed {
        logic               bad;
        logic [DIGIT_W-1:0] digit;
    } char_class_t;

    typedef struct packed {
        logic               is_decode;
        logic [NUM_W-1:0]   number;
        logic [DIGIT_W-1:0] digit;
        logic               bad;
        logic               last;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              digit_is_last;
        logic [NUM_W-1:0]  number_out;
        logic              bad_char;
        logic              is_decode_result;
    } res_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_EMIT
    } back_state_t;

    function automatic char_class_t char_class(input logic [CHAR_W-1:0] c);
        char_class_t r;
        r.bad   = 1'b0;
        r.digit = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            r.digit = DIGIT_W'(c - CH_ZERO);
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            r.digit = DIGIT_W'(c - CH_LOWER_A) + LOWER_BASE;
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            r.digit = DIGIT_W'(c - CH_UPPER_A) + UPPER_BASE;
        end else begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < LOWER_BASE) begin
            c = CH_ZERO + CHAR_W'(d);
        end else if (d < UPPER_BASE) begin
            c = CH_LOWER_A + CHAR_W'(d - LOWER_BASE);
        end else begin
            c = CH_UPPER_A + CHAR_W'(d - UPPER_BASE);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ src/b62_if.sv @@
// ----------------------------------------------------------------------------
// Base-62 codec channel interfaces
// Valid/ready channels for requests into the codec and results out of it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface b62_in_if
    import b62_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [NUM_W-1:0]  number_in;
    logic [CHAR_W-1:0] char_in;
    logic              char_is_last;

    modport source (output valid, mode, number_in, char_in, char_is_last, input ready);
    modport sink   (input valid, mode, number_in, char_in, char_is_last, output ready);
endinterface

interface b62_out_if
    import b62_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] digit_char;
    logic              digit_is_last;
    logic [NUM_W-1:0]  number_out;
    logic              bad_char;
    logic              is_decode_result;

    modport source (output valid, digit_char, digit_is_last, number_out, bad_char,
                    is_decode_result, input ready);
    modport sink   (input valid, digit_char, digit_is_last, number_out, bad_char,
                    is_decode_result, output ready);
endinterface

`default_nettype wire

@@ src/b62_front.sv @@
// ----------------------------------------------------------------------------
// Base-62 codec front end
// Takes requests, maps decode characters to digit values and flags
// characters outside the alphabet, and pushes the command into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b62_front
    import b62_pkg::*;
(
    b62_in_if.sink    requests,
    input  q_status_t q_status,
    output logic      push,
    output cmd_t      push_cmd
);

    char_class_t cls;

    always_comb
    begin
        cls = char_class(requests.char_in);
    end

    assign requests.ready = !q_status.full;
    assign push           = requests.valid && !q_status.full;

    always_comb
    begin
        push_cmd.is_decode = requests.mode;
        push_cmd.number    = requests.number_in;
        push_cmd.digit     = cls.digit;
        push_cmd.bad       = cls.bad;
        push_cmd.last      = requests.char_is_last;
    end

endmodule

`default_nettype wire

@@ src/b62_queue.sv @@
// ----------------------------------------------------------------------------
// Base-62 codec command queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b62_queue
    import b62_pkg::*;
#(
    parameter int DEPTH = DEFAULT_QUEUE_DEPTH
)(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      pop_cmd,
    output q_status_t q_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign pop_cmd        = entry_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == CNT_W'(DEPTH));
    assign q_status.empty = (count_reg == '0);

endmodule

`default_nettype wire

@@ src/b62_back.sv @@
// ----------------------------------------------------------------------------
// Base-62 codec back end
// Runs encode commands through a chunked divide-by-62 unit, stacking the
// remainders and emitting them most significant first, and folds decode
// commands into the accumulator. Results leave through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b62_back
    import b62_pkg::*;
#(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
)(
    input  logic      clk,
    input  logic      rst_n,
    input  q_status_t q_status,
    input  cmd_t      cmd,
    output logic      pop,
    b62_out_if.source results
);

    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int CHUNK_IX_W = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int HALF_RADIX = RADIX / 2;
    localparam int HALF_W     = CHUNK_W + DIGIT_W - 1;
    localparam int SHIFT      = HALF_W + $clog2(HALF_RADIX);
    localparam int RECIP_W    = SHIFT - $clog2(HALF_RADIX) + 1;
    localparam int PROD_W     = HALF_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SHIFT) / HALF_RADIX);

    back_state_t state_reg;
    back_state_t state_next;

    logic [NUM_W-1:0]      val_reg;
    logic [NUM_W-1:0]      val_next;
    logic [DIGIT_W-1:0]    rem_reg;
    logic [DIGIT_W-1:0]    rem_next;
    logic [CHUNK_IX_W-1:0] chunk_reg;
    logic [CHUNK_IX_W-1:0] chunk_next;
    logic [CNT_W-1:0]      ndig_reg;
    logic [CNT_W-1:0]      ndig_next;
    logic [DIGIT_W-1:0]    dig_reg  [MAX_DIGITS];
    logic [DIGIT_W-1:0]    dig_next [MAX_DIGITS];
    logic [NUM_W-1:0]      acc_reg;
    logic [NUM_W-1:0]      acc_next;
    logic                  bad_reg;
    logic                  bad_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    res_t                  out_reg;
    res_t                  out_next;

    logic [CHUNK_W-1:0]         chunk_val;
    logic [HALF_W-1:0]          half_n;
    logic                       low_bit;
    logic [PROD_W-1:0]          prod;
    logic [CHUNK_W-1:0]         q_est;
    logic [HALF_W-1:0]          r_full;
    logic [DIGIT_W-1:0]         r_est;
    logic                       fix;
    logic [CHUNK_W-1:0]         quot;
    logic [DIGIT_W-1:0]         r_half;
    logic [DIGIT_W-1:0]         rem62;
    logic                       quot_nonzero;
    logic [CNT_W-1:0]           ndig_inc;
    logic                       more;
    logic                       out_free;
    logic [NUM_W-1:0]           d_ext;
    logic [NUM_W-1:0]           acc_sum;

    // One 16-bit step of the long division by 62: the running value is
    // split into its low bit and a half that is divided by 31 through a
    // reciprocal multiply with a single correction.
    always_comb
    begin
        chunk_val    = val_reg[int'(chunk_reg) * CHUNK_W +: CHUNK_W];
        {half_n, low_bit} = {rem_reg, chunk_val};
        prod         = PROD_W'(half_n) * PROD_W'(RECIP);
        q_est        = prod[SHIFT +: CHUNK_W];
        r_full       = half_n - HALF_W'(q_est) * HALF_W'(HALF_RADIX);
        r_est        = r_full[DIGIT_W-1:0];
        fix          = (r_est >= DIGIT_W'(HALF_RADIX));
        quot         = q_est + CHUNK_W'(fix);
        r_half       = fix ? r_est - DIGIT_W'(HALF_RADIX) : r_est;
        rem62        = {r_half[DIGIT_W-2:0], low_bit};
        quot_nonzero = (val_reg[NUM_W-1:CHUNK_W] != '0) || (quot != '0);
        ndig_inc     = ndig_reg + 1'b1;
        more         = quot_nonzero && (ndig_inc < CNT_W'(MAX_DIGITS));
    end

    always_comb
    begin
        out_free = !out_valid_reg || results.ready;
        d_ext    = cmd.bad ? '1 : NUM_W'(cmd.digit);
        acc_sum  = (acc_reg << RADIX_HI_SH) - (acc_reg << RADIX_LO_SH) + d_ext;
        pop      = (state_reg == BK_IDLE) && !q_status.empty
                   && (!(cmd.is_decode && cmd.last) || out_free);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (pop && !cmd.is_decode) begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (chunk_reg == '0 && !more) begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (out_free && ndig_reg == CNT_W'(1)) begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        val_next       = val_reg;
        rem_next       = rem_reg;
        chunk_next     = chunk_reg;
        ndig_next      = ndig_reg;
        dig_next       = dig_reg;
        acc_next       = acc_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_next       = out_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (pop) begin
                    if (cmd.is_decode) begin
                        if (cmd.last) begin
                            out_valid_next            = 1'b1;
                            out_next.digit_char       = '0;
                            out_next.digit_is_last    = 1'b0;
                            out_next.number_out       = acc_sum;
                            out_next.bad_char         = bad_reg || cmd.bad;
                            out_next.is_decode_result = 1'b1;
                            acc_next                  = '0;
                            bad_next                  = 1'b0;
                        end else begin
                            acc_next = acc_sum;
                            bad_next = bad_reg || cmd.bad;
                        end
                    end else begin
                        val_next   = cmd.number;
                        rem_next   = '0;
                        chunk_next = CHUNK_IX_W'(NUM_CHUNKS - 1);
                        ndig_next  = '0;
                    end
                end
            end
            BK_DIV:
            begin
                val_next[int'(chunk_reg) * CHUNK_W +: CHUNK_W] = quot;
                if (chunk_reg != '0) begin
                    rem_next   = rem62;
                    chunk_next = chunk_reg - 1'b1;
                end else begin
                    dig_next[0] = rem62;
                    for (int k = 1; k < MAX_DIGITS; k++) begin
                        dig_next[k] = dig_reg[k-1];
                    end
                    ndig_next  = ndig_inc;
                    rem_next   = '0;
                    chunk_next = CHUNK_IX_W'(NUM_CHUNKS - 1);
                end
            end
            BK_EMIT:
            begin
                if (out_free) begin
                    out_valid_next            = 1'b1;
                    out_next.digit_char       = digit_char(dig_reg[0]);
                    out_next.digit_is_last    = (ndig_reg == CNT_W'(1));
                    out_next.number_out       = '0;
                    out_next.bad_char         = 1'b0;
                    out_next.is_decode_result = 1'b0;
                    for (int k = 0; k < MAX_DIGITS - 1; k++) begin
                        dig_next[k] = dig_reg[k+1];
                    end
                    ndig_next = ndig_reg - 1'b1;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= BK_IDLE;
            chunk_reg     <= '0;
            ndig_reg      <= '0;
            acc_reg       <= '0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            chunk_reg     <= chunk_next;
            ndig_reg      <= ndig_next;
            acc_reg       <= acc_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        rem_reg <= rem_next;
        dig_reg <= dig_next;
        out_reg <= out_next;
    end

    assign results.valid            = out_valid_reg;
    assign results.digit_char       = out_reg.digit_char;
    assign results.digit_is_last    = out_reg.digit_is_last;
    assign results.number_out       = out_reg.number_out;
    assign results.bad_char         = out_reg.bad_char;
    assign results.is_decode_result = out_reg.is_decode_result;

endmodule

`default_nettype wire

@@ src/base62_number_codec.sv @@
// ----------------------------------------------------------------------------
// Base-62 number codec
// Converts unsigned 64-bit numbers to and from text over 0-9, a-z, A-Z.
// ----------------------------------------------------------------------------
// An encode request yields one digit result per base-62 digit, most
// significant first, the last one marked, and at most eleven digits for a
// 64-bit number. The back end first finds every digit by repeated 16-bit
// divide-by-62 steps, which share one reciprocal multiplier, and then sends
// the digits out one by one. A decode request carries one character; only
// the character marked last produces a result, holding the accumulated
// value and the bad-character flag, after which the string state clears.
// Encode requests leave an unfinished decode string untouched. A queue, two
// entries deep by default, lets new requests enter while the back end works
// or a result waits to be taken.
`timescale 1ns / 1ps
`default_nettype none

module base62_number_codec
    import b62_pkg::*;
#(
    parameter int MAX_DIGITS  = DEFAULT_MAX_DIGITS,
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)(
    input  logic      clk,
    input  logic      rst_n,
    b62_in_if.sink    requests,
    b62_out_if.source results
);

    q_status_t q_status;
    logic      push;
    cmd_t      push_cmd;
    logic      pop;
    cmd_t      pop_cmd;

    b62_front u_front (
        .requests (requests),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    b62_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_status (q_status)
    );

    b62_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .cmd      (pop_cmd),
        .pop      (pop),
        .results  (results)
    );

endmodule

`default_nettype wire

@@ src/b62_checker.sv @@
// ----------------------------------------------------------------------------
// Base-62 codec port checker
// Watches the result channel of the codec and is bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "base62_number_codec_macros.svh"

module b62_checker
    import b62_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_ready,
    input logic [CHAR_W-1:0] res_digit_char,
    input logic              res_digit_is_last,
    input logic [NUM_W-1:0]  res_number_out,
    input logic              res_bad_char,
    input logic              res_is_decode
);

    logic                     res_stall;
    logic [CHAR_W+NUM_W+2:0]  res_bits;
    logic                     digit_res;
    logic                     decode_res;
    logic                     digit_ok;
    logic                     digit_clean;
    logic                     decode_clean;

    assign res_stall    = res_valid && !res_ready;
    assign res_bits     = {res_digit_char, res_digit_is_last, res_number_out, res_bad_char,
                           res_is_decode};
    assign digit_res    = res_valid && !res_is_decode;
    assign decode_res   = res_valid && res_is_decode;
    assign digit_ok     = (res_digit_char >= CH_ZERO && res_digit_char <= CH_NINE)
                          || (res_digit_char >= CH_LOWER_A && res_digit_char <= CH_LOWER_Z)
                          || (res_digit_char >= CH_UPPER_A && res_digit_char <= CH_UPPER_Z);
    assign digit_clean  = (res_number_out == '0) && !res_bad_char;
    assign decode_clean = (res_digit_char == '0) && !res_digit_is_last;

    `B62_ASSERT_NEXT(a_result_holds, res_stall, res_valid && $stable(res_bits), "Stalled result changed")

    `B62_ASSERT_NOW(a_digit_in_alphabet, digit_res, digit_ok, "Encoded digit outside the alphabet")

    `B62_ASSERT_NOW(a_digit_fields, digit_res, digit_clean, "Digit result carries decode fields")

    `B62_ASSERT_NOW(a_decode_fields, decode_res, decode_clean, "Decode result carries digit fields")

endmodule

bind base62_number_codec b62_checker u_b62_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .res_valid         (results.valid),
    .res_ready         (results.ready),
    .res_digit_char    (results.digit_char),
    .res_digit_is_last (results.digit_is_last),
    .res_number_out    (results.number_out),
    .res_bad_char      (results.bad_char),
    .res_is_decode     (results.is_decode_result)
);

`default_nettype wire
